// File: rtl/oef_pkg.sv
// ----------------------------------------------------------------------------
// oef_pkg: shared types and constants of the one euro filter
// Widths of the shared serial arithmetic unit, its request and response
// structs, register indexes and the fixed-point constants of the filter.
// ----------------------------------------------------------------------------
package oef_pkg;

    localparam int SAMPLE_WIDTH_DEF = 32;

    // Shared arithmetic unit widths
    localparam int ACC_W = 80;
    localparam int OPB_W = 40;
    localparam int CNT_W = 7;

    // Iteration counts of each operation
    localparam logic [CNT_W-1:0] RATE_MUL_N  = 7'd20;
    localparam logic [CNT_W-1:0] RATE_DIV_N  = 7'd69;
    localparam logic [CNT_W-1:0] ALPHA_MUL_N = 7'd32;
    localparam logic [CNT_W-1:0] ALPHA_DIV_N = 7'd63;
    localparam logic [CNT_W-1:0] SMOOTH_N    = 7'd25;
    localparam logic [CNT_W-1:0] GAIN_N      = 7'd32;

    // Left shifts that align a numerator to the top of the accumulator
    localparam int RATE_ALIGN  = ACC_W - 69;
    localparam int ALPHA_ALIGN = ACC_W - 39;

    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [64:0] TAU_SCALE    = 65'd10430378350;
    localparam int          ALPHA_BITS   = 24;

    localparam logic signed [47:0] RATE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] RATE_MIN = 48'sh8000_0000_0000;

    localparam logic [31:0] FLOOR_CUTOFF_RST = 32'd65536;
    localparam logic [31:0] SPEED_GAIN_RST   = 32'd0;
    localparam logic [31:0] RATE_CUTOFF_RST  = 32'd65536;

    // Configuration register indexes
    localparam logic [1:0] CFG_FLOOR_CUTOFF = 2'd0;
    localparam logic [1:0] CFG_SPEED_GAIN   = 2'd1;
    localparam logic [1:0] CFG_RATE_CUTOFF  = 2'd2;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic             start;
        t_alu_op          op;
        logic [CNT_W-1:0] count;
        logic [ACC_W-1:0] a;
        logic [OPB_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [ACC_W-1:0] result;
    } t_alu_rsp;

endpackage

// File: rtl/oef_alu.sv
// ----------------------------------------------------------------------------
// oef_alu: shared serial multiply / divide unit
// Shift-add multiply (one multiplier bit a cycle) and restoring divide
// (one quotient bit a cycle) in one unit.
// ----------------------------------------------------------------------------
module oef_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  oef_pkg::t_alu_req i_req,
    output oef_pkg::t_alu_rsp o_rsp
);

    logic                      r_busy;
    logic                      r_done;
    oef_pkg::t_alu_op          r_op;
    logic [oef_pkg::CNT_W-1:0] r_cnt;
    logic [oef_pkg::ACC_W-1:0] r_a;
    logic [oef_pkg::OPB_W-1:0] r_b;
    logic [oef_pkg::ACC_W-1:0] r_acc;
    logic [oef_pkg::OPB_W-1:0] r_rem;

    logic [oef_pkg::OPB_W:0]   w_rem_sh;
    logic [oef_pkg::OPB_W:0]   w_rem_sub;
    logic                      w_ge;

    // Restoring divide step: numerator bits come from the top of r_a
    assign w_rem_sh  = {r_rem, r_a[oef_pkg::ACC_W-1]};
    assign w_ge      = w_rem_sh >= {1'b0, r_b};
    assign w_rem_sub = w_rem_sh - {1'b0, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy) begin
                if (i_req.start) begin
                    r_busy <= 1'b1;
                    r_op   <= i_req.op;
                    r_cnt  <= i_req.count;
                    r_a    <= i_req.a;
                    r_b    <= i_req.b;
                    r_acc  <= '0;
                    r_rem  <= '0;
                end
            end else begin
                case (r_op)
                    oef_pkg::ALU_MUL: begin
                        if (r_b[0]) begin
                            r_acc <= r_acc + r_a;
                        end
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                    end
                    default: begin
                        r_rem <= w_ge ? w_rem_sub[oef_pkg::OPB_W-1:0]
                                      : w_rem_sh[oef_pkg::OPB_W-1:0];
                        r_a   <= r_a << 1;
                        r_acc <= {r_acc[oef_pkg::ACC_W-2:0], w_ge};
                    end
                endcase
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == oef_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule

// File: rtl/one_euro_filter_top.sv
// ----------------------------------------------------------------------------
// one_euro_filter_top: adaptive low-pass (one euro) filter
// Sequencer and state of the filter around one shared serial unit.
// ----------------------------------------------------------------------------
// Each request carries a signed Q16.16 sample, a microsecond timestamp and a
// restart flag, and yields exactly one filtered value. The first request
// after reset, or one with restart set, seeds the filter and loads the
// sample into the output register once that register is free. Every other
// request runs all multiplies and divides one bit a cycle on the single
// shared multiply/divide unit (rate multiply 20, rate divide 69, two alpha
// multiplies of 32, two alpha divides of 63, two smoothing multiplies of 25
// and one gain multiply of 32 steps), each with an issue state and a wait
// state, plus a normalize state per alpha that halves both terms until the
// divisor is below 2^39. The next request can be taken in the cycle after
// the result is loaded. The input side stalls while a request is in work;
// a finished value waits in the output register, so the next request is
// taken while the value is still stalled downstream. Write the
// configuration registers (floor cutoff, speed gain, rate cutoff; Q16.16)
// only while the block is idle.
// ----------------------------------------------------------------------------
module one_euro_filter_top #(
    parameter int SAMPLE_WIDTH = oef_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    // Input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [31:0]                    i_time_us,
    input  logic                           i_restart,
    // Output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [31:0]             o_filtered
);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_RMUL_GO, S_RMUL_W, S_RDIV_GO, S_RDIV_W,
        S_AMUL_GO, S_AMUL_W, S_NORM, S_ADIV_GO, S_ADIV_W,
        S_SMUL_GO, S_SMUL_W, S_CMUL_GO, S_CMUL_W, S_OUT
    } t_state;

    localparam logic [47:0] RATE_MIN_U = oef_pkg::RATE_MIN;
    localparam logic [47:0] RATE_MAX_U = oef_pkg::RATE_MAX;

    t_state r_state;

    // Configuration
    logic [31:0] r_floor_cutoff;
    logic [31:0] r_speed_gain;
    logic [31:0] r_rate_cutoff;

    // Filter state
    logic signed [SAMPLE_WIDTH-1:0] r_prev_sample;
    logic [31:0]                    r_prev_time;
    logic signed [SAMPLE_WIDTH-1:0] r_smooth_value;
    logic signed [47:0]             r_smooth_rate;
    logic                           r_seeded;

    // Working registers of one request
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic [31:0]                    r_t;
    logic [31:0]                    r_dt;
    logic [48:0]                    r_diff_mag;
    logic                           r_diff_neg;
    logic signed [47:0]             r_rate;
    logic [31:0]                    r_cutoff;
    logic                           r_phase;   // 0: rate, 1: value
    logic [63:0]                    r_m;
    logic [64:0]                    r_d;
    logic [24:0]                    r_alpha;
    logic [48:0]                    r_dmag;
    logic                           r_dneg;

    // Output register
    logic                           r_out_valid;
    logic signed [31:0]             r_filtered;

    oef_pkg::t_alu_req w_req;
    oef_pkg::t_alu_rsp w_rsp;

    logic [31:0]        w_raw_dt;
    logic [31:0]        w_dt;
    logic signed [49:0] w_diff;
    logic signed [49:0] w_delta;
    logic [79:0]        w_res;
    logic [47:0]        w_rate_sat;
    logic [48:0]        w_step;
    logic signed [49:0] w_new_rate;
    logic signed [49:0] w_new_value;
    logic [47:0]        w_rate_mag;
    logic [63:0]        w_extra;
    logic [31:0]        w_limit;
    logic [31:0]        w_new_cutoff;
    logic [63:0]        w_value_ext;

    oef_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign w_res = w_rsp.result;

    // Clamp time going backwards or standing still to 1 us
    assign w_raw_dt = r_t - r_prev_time;
    assign w_dt     = (w_raw_dt == '0 || w_raw_dt[31]) ? 32'd1 : w_raw_dt;
    assign w_diff   = 50'(r_x) - 50'(r_prev_sample);

    // Saturate the rate quotient to the 48-bit signed range
    always_comb begin
        if (|w_res[79:47]) begin
            w_rate_sat = r_diff_neg ? RATE_MIN_U : RATE_MAX_U;
        end else begin
            w_rate_sat = r_diff_neg ? 48'(-w_res[47:0]) : w_res[47:0];
        end
    end

    // Distance from the smoothed value to its target
    assign w_delta = r_phase ? (50'(r_x) - 50'(r_smooth_value))
                             : (50'(r_rate) - 50'(r_smooth_rate));

    // Step toward the target, rounded toward zero
    assign w_step      = w_res[oef_pkg::ALPHA_BITS +: 49];
    assign w_new_rate  = r_dneg ? 50'(r_smooth_rate) - 50'(w_step)
                                : 50'(r_smooth_rate) + 50'(w_step);
    assign w_new_value = r_dneg ? 50'(r_smooth_value) - 50'(w_step)
                                : 50'(r_smooth_value) + 50'(w_step);

    assign w_rate_mag = r_smooth_rate[47] ? 48'(-r_smooth_rate) : r_smooth_rate;

    // Value cutoff: floor cutoff plus gain times rate magnitude, saturated
    assign w_extra      = w_res[79:16];
    assign w_limit      = 32'hFFFF_FFFF - r_floor_cutoff;
    assign w_new_cutoff = (w_extra > 64'(w_limit)) ? 32'hFFFF_FFFF
                                                   : r_floor_cutoff + w_extra[31:0];

    assign w_value_ext = 64'($unsigned(r_smooth_value));

    // Requests to the shared unit
    always_comb begin
        w_req       = '0;
        w_req.op    = oef_pkg::ALU_MUL;
        unique case (r_state)
            S_RMUL_GO: begin
                w_req.start = 1'b1;
                w_req.count = oef_pkg::RATE_MUL_N;
                w_req.a     = 80'(r_diff_mag);
                w_req.b     = 40'(oef_pkg::USEC_PER_SEC);
            end
            S_RDIV_GO: begin
                w_req.start = 1'b1;
                w_req.op    = oef_pkg::ALU_DIV;
                w_req.count = oef_pkg::RATE_DIV_N;
                w_req.a     = w_res << oef_pkg::RATE_ALIGN;
                w_req.b     = 40'(r_dt);
            end
            S_AMUL_GO: begin
                w_req.start = 1'b1;
                w_req.count = oef_pkg::ALPHA_MUL_N;
                w_req.a     = 80'(r_cutoff);
                w_req.b     = 40'(r_dt);
            end
            S_ADIV_GO: begin
                w_req.start = 1'b1;
                w_req.op    = oef_pkg::ALU_DIV;
                w_req.count = oef_pkg::ALPHA_DIV_N;
                w_req.a     = 80'(r_m[38:0]) << oef_pkg::ALPHA_ALIGN;
                w_req.b     = 40'(r_d[38:0]);
            end
            S_SMUL_GO: begin
                w_req.start = 1'b1;
                w_req.count = oef_pkg::SMOOTH_N;
                w_req.a     = 80'(r_dmag);
                w_req.b     = 40'(r_alpha);
            end
            S_CMUL_GO: begin
                w_req.start = 1'b1;
                w_req.count = oef_pkg::GAIN_N;
                w_req.a     = 80'(w_rate_mag);
                w_req.b     = 40'(r_speed_gain);
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_floor_cutoff <= oef_pkg::FLOOR_CUTOFF_RST;
            r_speed_gain   <= oef_pkg::SPEED_GAIN_RST;
            r_rate_cutoff  <= oef_pkg::RATE_CUTOFF_RST;
            r_prev_sample  <= '0;
            r_prev_time    <= '0;
            r_smooth_value <= '0;
            r_smooth_rate  <= '0;
            r_seeded       <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            // Configuration writes; ignore indexes beyond the list
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    oef_pkg::CFG_FLOOR_CUTOFF: r_floor_cutoff <= i_cfg_data;
                    oef_pkg::CFG_SPEED_GAIN:   r_speed_gain   <= i_cfg_data;
                    oef_pkg::CFG_RATE_CUTOFF:  r_rate_cutoff  <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the output once taken downstream, unless refilled below
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x <= i_sample;
                        r_t <= i_time_us;
                        if (!r_seeded || i_restart) begin
                            // Seed: pass the sample through, zero the rate
                            r_prev_sample  <= i_sample;
                            r_prev_time    <= i_time_us;
                            r_smooth_value <= i_sample;
                            r_smooth_rate  <= '0;
                            r_seeded       <= 1'b1;
                            r_state        <= S_OUT;
                        end else begin
                            r_state <= S_DIFF;
                        end
                    end
                end
                S_DIFF: begin
                    r_dt       <= w_dt;
                    r_diff_neg <= w_diff[49];
                    r_diff_mag <= w_diff[49] ? 49'(-w_diff) : 49'(w_diff);
                    r_state    <= S_RMUL_GO;
                end
                S_RMUL_GO: r_state <= S_RMUL_W;
                S_RMUL_W: begin
                    if (w_rsp.done) begin
                        r_state <= S_RDIV_GO;
                    end
                end
                S_RDIV_GO: r_state <= S_RDIV_W;
                S_RDIV_W: begin
                    if (w_rsp.done) begin
                        r_rate   <= w_rate_sat;
                        r_phase  <= 1'b0;
                        r_cutoff <= r_rate_cutoff;
                        r_state  <= S_AMUL_GO;
                    end
                end
                S_AMUL_GO: r_state <= S_AMUL_W;
                S_AMUL_W: begin
                    if (w_rsp.done) begin
                        r_m     <= w_res[63:0];
                        r_d     <= 65'(w_res[63:0]) + oef_pkg::TAU_SCALE;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: begin
                    // Shift both terms until the divisor fits in 39 bits
                    if (r_d[64:39] != '0) begin
                        r_m <= r_m >> 1;
                        r_d <= r_d >> 1;
                    end else begin
                        r_state <= S_ADIV_GO;
                    end
                end
                S_ADIV_GO: r_state <= S_ADIV_W;
                S_ADIV_W: begin
                    if (w_rsp.done) begin
                        r_alpha <= w_res[24:0];
                        r_dneg  <= w_delta[49];
                        r_dmag  <= w_delta[49] ? 49'(-w_delta) : 49'(w_delta);
                        r_state <= S_SMUL_GO;
                    end
                end
                S_SMUL_GO: r_state <= S_SMUL_W;
                S_SMUL_W: begin
                    if (w_rsp.done) begin
                        if (!r_phase) begin
                            r_smooth_rate <= w_new_rate[47:0];
                            r_state       <= S_CMUL_GO;
                        end else begin
                            r_smooth_value <= w_new_value[SAMPLE_WIDTH-1:0];
                            r_prev_sample  <= r_x;
                            r_prev_time    <= r_t;
                            r_state        <= S_OUT;
                        end
                    end
                end
                S_CMUL_GO: r_state <= S_CMUL_W;
                S_CMUL_W: begin
                    if (w_rsp.done) begin
                        r_cutoff <= w_new_cutoff;
                        r_phase  <= 1'b1;
                        r_state  <= S_AMUL_GO;
                    end
                end
                S_OUT: begin
                    // Hold until the output register is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_filtered  <= w_value_ext[31:0];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

endmodule

// File: rtl/oef_checker.sv
// ----------------------------------------------------------------------------
// oef_checker: port-level checks of the one euro filter
// Watches the handshakes and the sequencing seen at the top-level ports.
// ----------------------------------------------------------------------------
module oef_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_filtered
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_filtered))
        else $error("stalled output request dropped or changed");

    // Take no new request right after one is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while previous request in work");

    // Come out of reset ready for a request
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

    // Raise a result only after a request went in
    a_no_spurious_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output raised with no request in work");

endmodule

bind one_euro_filter_top oef_checker u_oef_checker (.*);

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for one_euro_filter_top
// Drives timestamped samples with random gaps and output stalls, predicts
// each filtered value in fixed point, and compares every result in order.
// ----------------------------------------------------------------------------

class euro_scoreboard;
    // Configuration and filter state, mirroring the block
    logic [31:0]        floor_cutoff;
    logic [31:0]        gain;
    logic [31:0]        rate_cutoff;
    logic signed [63:0] last_sample;
    logic [31:0]        last_time;
    logic signed [63:0] value_acc;
    logic signed [63:0] rate_acc;
    bit                 primed;
    logic [31:0]        filtered_q[$];
    int                 errors;

    function new();
        floor_cutoff = oef_pkg::FLOOR_CUTOFF_RST;
        gain         = oef_pkg::SPEED_GAIN_RST;
        rate_cutoff  = oef_pkg::RATE_CUTOFF_RST;
        last_sample  = 0;
        last_time    = 0;
        value_acc    = 0;
        rate_acc     = 0;
        primed       = 0;
        errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            oef_pkg::CFG_FLOOR_CUTOFF: floor_cutoff = val;
            oef_pkg::CFG_SPEED_GAIN:   gain         = val;
            oef_pkg::CFG_RATE_CUTOFF:  rate_cutoff  = val;
            default: ;
        endcase
    endfunction

    function logic [63:0] abs64(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    // alpha = r/(1+r) as a 24-bit fraction
    function logic [31:0] alpha(logic [31:0] c, logic [31:0] dt);
        logic [63:0] m;
        logic [63:0] d;
        m = 64'(c) * 64'(dt);
        d = m + 64'd10430378350;
        while ((d >> 39) != 0) begin
            m = m >> 1;
            d = d >> 1;
        end
        return 32'((m << oef_pkg::ALPHA_BITS) / d);
    endfunction

    function logic signed [63:0] approach(logic signed [63:0] s, logic signed [63:0] x,
                                          logic [31:0] a);
        logic signed [63:0] delta;
        logic [63:0]        mag;
        logic [63:0]        stp;
        delta = x - s;
        mag   = abs64(delta);
        stp   = (mag >> 24) * 64'(a) + (((mag & 64'hFF_FFFF) * 64'(a)) >> 24);
        return delta < 0 ? s - $signed(stp) : s + $signed(stp);
    endfunction

    function logic signed [63:0] slope(logic signed [63:0] diff, logic [31:0] dt);
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] quo;
        logic [63:0] rem;
        mag = abs64(diff);
        quo = mag / 64'(dt);
        rem = mag % 64'(dt);
        if (quo >= (64'd1 << 28)) q = 64'd1 << 47;
        else q = quo * 64'd1000000 + (rem * 64'd1000000) / 64'(dt);
        if (diff < 0) return q >= (64'd1 << 47) ? -(64'sd1 <<< 47) : -$signed(q);
        return q > ((64'd1 << 47) - 1) ? (64'sd1 <<< 47) - 1 : $signed(q);
    endfunction

    function void note_request(logic signed [31:0] smp, logic [31:0] t, logic rst);
        logic signed [63:0] x;
        logic [31:0]        raw;
        logic [31:0]        dt;
        logic [63:0]        mag;
        logic [63:0]        extra;
        logic [31:0]        cut;
        x = smp;
        if (!primed || rst) begin
            value_acc = x;
            rate_acc  = 0;
            primed    = 1;
        end else begin
            raw = t - last_time;
            dt  = (raw == 0 || raw[31]) ? 32'd1 : raw;
            rate_acc = approach(rate_acc, slope(x - last_sample, dt),
                                alpha(rate_cutoff, dt));
            mag   = abs64(rate_acc);
            extra = (mag >> 16) * 64'(gain) + (((mag & 64'hFFFF) * 64'(gain)) >> 16);
            cut   = (extra > 64'(32'hFFFF_FFFF - floor_cutoff)) ? 32'hFFFF_FFFF
                                                                : floor_cutoff + 32'(extra);
            value_acc = approach(value_acc, x, alpha(cut, dt));
        end
        last_sample = x;
        last_time   = t;
        filtered_q.push_back(value_acc[31:0]);
    endfunction

    function void check_result(logic [31:0] got);
        logic [31:0] want;
        if (filtered_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = filtered_q.pop_front();
        if (want !== got) begin
            $display("%0t: filtered mismatch expected %h actual %h", $time, want, got);
            errors++;
        end
    endfunction
endclass

module testbench;
    // Register index outside the list, written to check that it is ignored
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] sample;
    logic [31:0]        time_us;
    logic               restart;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] filtered;

    euro_scoreboard sb;
    int  cycles;
    bit  hold_off;     // long receiver stall requested by the sender side
    logic [31:0] now_us;

    one_euro_filter_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_sample(sample), .i_time_us(time_us), .i_restart(restart),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_filtered(filtered)
    );

    always begin
        clk = 1'b1; #6;
        clk = 1'b0; #6;
    end

    initial begin
        rst_n = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
        in_valid = 0; sample = 0; time_us = 0; restart = 0;
        out_stall = 0; hold_off = 0;
        sb = new();
    end

    // Watchdog: generous bound over ~1500 requests plus long gaps
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 10000000) begin
            $display("FAIL");
            $finish;
        end
    end

    // Check every accepted result against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(filtered);
    end

    // Receiver: stalls drawn at random each clock, plus an explicit hold-off
    always @(posedge clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (hold_off) out_stall <= 1'b1;
        else if (r < 50) out_stall <= 1'b0;
        else if (r < 97) out_stall <= ($urandom_range(0, 2) == 0);
        else out_stall <= ($urandom_range(0, 1) == 0);
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 600);
    endfunction

    task automatic idle(int n);
        repeat (n) @(posedge clk);
    endtask

    // Offer one request and hold it until accepted; valid stays up afterwards
    // until the next request or a pause takes it down
    task automatic send(logic signed [31:0] s, logic [31:0] t, logic r, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            idle(gap);
        end
        in_valid <= 1'b1;
        sample   <= s;
        time_us  <= t;
        restart  <= r;
        do @(posedge clk); while (in_stall);
        sb.note_request(s, t, r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.filtered_q.size() != 0) @(posedge clk);
        idle(500);   // seeding items finish quickly; leave room for any work in flight
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    // Random sample near zero, with occasional extremes
    function automatic logic [31:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom();
        if (r == 1) return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
    endfunction

    function automatic logic [31:0] rand_dt();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return $urandom();            // may run backwards
        if (r == 1) return 0;
        if (r < 4)  return $urandom_range(1, 20);
        return $urandom_range(500, 20000);
    endfunction

    initial begin
        logic [31:0] cfgs [6][3];
        int k;
        int p;
        cfgs = '{'{32'h0001_0000, 32'h0000_0000, 32'h0001_0000},
                 '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000},
                 '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                 '{32'h0000_8000, 32'h0000_0100, 32'h0001_0000},
                 '{32'h0010_0000, 32'h0000_0010, 32'h0050_0000},
                 '{32'h0002_0000, 32'h0040_0000, 32'h0000_4000}};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: seed, extremes, time stall and reversal, restart, saturation
        now_us = 0;
        send(32'sh0001_0000, 32'd1000, 0, 0);
        send(32'sh0002_0000, 32'd2000, 0, 0);
        send(32'sh7FFF_FFFF, 32'd2000, 0, 1);   // time stands still, huge rate
        send(32'sh8000_0000, 32'd1500, 0, 0);   // time runs backwards
        send(32'sh8000_0000, 32'hFFFF_FFFF, 0, 0);
        send(32'sh0000_0000, 32'h0000_0010, 0, 0); // timestamp wrap
        send(32'sh1234_5678, 32'h0000_0020, 1, 0); // restart
        send(32'shFFFF_FFFF, 32'h7FFF_FFFF, 0, 3);
        send(32'sh0000_0001, 32'h8000_0020, 0, 0);
        send(32'sh0000_0000, 32'h0000_0000, 1, 0);
        drain();

        // Walk the settings; each phase random requests after a restart
        for (p = 0; p < 6; p++) begin
            write_cfg(oef_pkg::CFG_FLOOR_CUTOFF, cfgs[p][0]);
            write_cfg(oef_pkg::CFG_SPEED_GAIN, cfgs[p][1]);
            write_cfg(oef_pkg::CFG_RATE_CUTOFF, cfgs[p][2]);
            write_cfg(CFG_UNUSED, $urandom());     // unused index, must be ignored
            cfg_we <= 1'b0;
            for (k = 0; k < 250; k++) begin
                now_us = now_us + rand_dt();
                send(rand_sample(), now_us, ($urandom_range(0, 40) == 0) || k == 0,
                     gap_len());
                if (p == 2 && k == 100) begin
                    // hold the output off long enough for the block to back up
                    hold_off = 1;
                    fork
                        begin idle(3000); hold_off = 0; end
                    join_none
                end
                if (p == 3 && k == 120) drain();   // full pause until all results come
            end
            drain();
        end

        if (sb.errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule

// File: sim.f
rtl/oef_pkg.sv
rtl/oef_alu.sv
rtl/one_euro_filter_top.sv
rtl/oef_checker.sv
sim/testbench.sv
